### src/pfsd_pkg.sv
// Shared constants, types and reason codes for the per-flow sequence dedup block.
package pfsd_pkg;

  // Number of flows the table can track (1 to 4096).
  localparam int unsigned FLOW_ENTRIES = 64;

  localparam int unsigned FlowW = 32;
  localparam int unsigned SeqW  = 16;
  localparam int unsigned HdrW  = 16;
  localparam int unsigned AdjW  = 20;
  localparam int unsigned SegW  = 8;

  // Table index and fill count widths.
  localparam int unsigned IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(FLOW_ENTRIES + 1);

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    DrNone    = 3'd0,
    DrNoRh    = 3'd1,
    DrNotLast = 3'd2,
    DrDup     = 3'd3,
    DrNoInner = 3'd4,
    DrFull    = 3'd5
  } drop_reason_e;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    drop_reason_e          reason;
    logic [FlowW-1:0]      flow_id;
    logic [SeqW-1:0]       seq_num;
    logic [HdrW-1:0]       header_bytes;
    logic [AdjW-1:0]       next_hop_adj;
  } pfsd_item_t;

endpackage

### src/pfsd_front.sv
// Front part: accepts descriptor words and applies the early drop checks.
module pfsd_front import pfsd_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              has_routing_header_i,
  input  logic [SegW-1:0]   segments_left_i,
  input  logic              inner_is_ipv6_i,
  input  logic [FlowW-1:0]  flow_id_i,
  input  logic [SeqW-1:0]   seq_num_i,
  input  logic [HdrW-1:0]   header_bytes_i,
  input  logic [AdjW-1:0]   next_hop_adj_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pfsd_item_t        q_item_o
);

  drop_reason_e reason;

  // The checks run in a fixed order; segments left only matters with a header.
  always_comb begin
    if (has_routing_header_i && (segments_left_i != '0)) begin
      reason = DrNotLast;
    end else if (!inner_is_ipv6_i) begin
      reason = DrNoInner;
    end else if (!has_routing_header_i) begin
      reason = DrNoRh;
    end else begin
      reason = DrNone;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.reason       = reason;
    q_item_o.flow_id      = flow_id_i;
    q_item_o.seq_num      = seq_num_i;
    q_item_o.header_bytes = header_bytes_i;
    q_item_o.next_hop_adj = next_hop_adj_i;
  end

endmodule

### src/pfsd_queue.sv
// Short FIFO that decouples the front from the table walk in the back.
module pfsd_queue import pfsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pfsd_item_t  item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output pfsd_item_t  item_o
);

  pfsd_item_t        slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### src/pfsd_back.sv
// Back part: walks the flow table, updates it and registers the result word.
module pfsd_back import pfsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pfsd_item_t        q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              forward_o,
  output logic [2:0]        drop_reason_o,
  output logic [HdrW-1:0]   strip_bytes_o,
  output logic [AdjW-1:0]   next_hop_out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  state_e                     state_q;
  pfsd_item_t                 item_q;
  drop_reason_e               res_reason_q;
  logic [IdxW-1:0]            idx_q;
  logic [CntW-1:0]            count_q;

  logic                       out_valid_q;
  drop_reason_e               out_reason_q;
  logic [HdrW-1:0]            out_strip_q;
  logic [AdjW-1:0]            out_nh_q;

  // Flow table: flow id in the upper bits, last sequence number below.
  // Entries fill from index zero and are never freed, so the fill count
  // stands in for the valid bits and also names the lowest free entry.
  logic [FlowW+SeqW-1:0]      mem_q [FLOW_ENTRIES];
  logic [FlowW+SeqW-1:0]      mem_rdata_q;
  logic                       mem_we;
  logic [IdxW-1:0]            mem_waddr;

  logic [FlowW-1:0]           rd_flow;
  logic [SeqW-1:0]            rd_seq;
  logic                       out_free;
  logic                       is_hit;
  logic                       is_dup;
  logic                       is_last;
  logic                       is_miss;
  logic                       is_full;

  assign rd_flow  = mem_rdata_q[FlowW+SeqW-1:SeqW];
  assign rd_seq   = mem_rdata_q[SeqW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  assign is_hit  = (state_q == S_CMP) && (rd_flow == item_q.flow_id);
  assign is_dup  = item_q.seq_num <= rd_seq;
  assign is_last = (CntW'(idx_q) + 1'b1) == count_q;
  assign is_miss = ((state_q == S_READ) && (count_q == '0)) ||
                   ((state_q == S_CMP) && !is_hit && is_last);
  assign is_full = (count_q == CntW'(FLOW_ENTRIES));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IdxW-1:0];
    if (is_hit) begin
      mem_we    = !is_dup;
      mem_waddr = idx_q;
    end else if (is_miss) begin
      mem_we    = !is_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= {item_q.flow_id, item_q.seq_num};
    end
    mem_rdata_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      res_reason_q <= DrNone;
      idx_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_reason_q <= DrNone;
      out_strip_q  <= '0;
      out_nh_q     <= '0;
    end else begin
      // In the done state the output register is either reloaded or still stalled.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            item_q       <= q_item_i;
            res_reason_q <= q_item_i.reason;
            idx_q        <= '0;
            state_q      <= (q_item_i.reason == DrNone) ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          if (is_miss) begin
            res_reason_q <= DrNone;
            count_q      <= count_q + 1'b1;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (is_hit) begin
            res_reason_q <= is_dup ? DrDup : DrNone;
            state_q      <= S_DONE;
          end else if (is_miss) begin
            res_reason_q <= is_full ? DrFull : DrNone;
            if (!is_full) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_reason_q <= res_reason_q;
            if (res_reason_q == DrNone) begin
              out_strip_q <= item_q.header_bytes;
              out_nh_q    <= item_q.next_hop_adj;
            end else begin
              out_strip_q <= '0;
              out_nh_q    <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign forward_o      = (out_reason_q == DrNone);
  assign drop_reason_o  = out_reason_q;
  assign strip_bytes_o  = out_strip_q;
  assign next_hop_out_o = out_nh_q;

endmodule

### src/per_flow_sequence_dedup.sv
// Top level of the per-flow sequence-number duplicate elimination block.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o | descriptor: routing header, segments,
//           |           |                         | inner IPv6, flow, seq, bytes, next hop
//   out     | output    | out_valid_o/out_stall_i | forward, drop_reason, strip_bytes,
//           |           |                         | next_hop_out
//
// An accepted word is written into a queue slot before the back pops it. A word that
// fails an early check is popped in the idle state and goes to the done state, which
// loads the output register. A word that reaches the flow table is popped, passes
// through the read and compare states for each entry read, up to and including the
// hit or every stored flow on a miss, and ends in the done state, reached straight
// from the read state while the table is still empty. The table memory has a single
// read port and is read one entry at a time. Reset is asynchronous and active low;
// it empties the queue and the table, since the fill count returns to zero. A stall
// on the output holds the result word and the back, and backs the queue up to in_stall_o.
module per_flow_sequence_dedup import pfsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              has_routing_header_i,
  input  logic [SegW-1:0]   segments_left_i,
  input  logic              inner_is_ipv6_i,
  input  logic [FlowW-1:0]  flow_id_i,
  input  logic [SeqW-1:0]   seq_num_i,
  input  logic [HdrW-1:0]   header_bytes_i,
  input  logic [AdjW-1:0]   next_hop_adj_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              forward_o,
  output logic [2:0]        drop_reason_o,
  output logic [HdrW-1:0]   strip_bytes_o,
  output logic [AdjW-1:0]   next_hop_out_o
);

  // Classified words flow from the front through the queue into the back.
  logic        q_full;
  logic        q_push;
  pfsd_item_t  q_in_item;
  logic        q_valid;
  logic        q_pop;
  pfsd_item_t  q_out_item;

  // The front resolves the early drop reasons in one pass, so the table walk
  // only ever sees words that really need a lookup, plus the dropped words in
  // order so that results leave in the order the descriptors arrived.
  pfsd_front u_front (
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .has_routing_header_i (has_routing_header_i),
    .segments_left_i      (segments_left_i),
    .inner_is_ipv6_i      (inner_is_ipv6_i),
    .flow_id_i            (flow_id_i),
    .seq_num_i            (seq_num_i),
    .header_bytes_i       (header_bytes_i),
    .next_hop_adj_i       (next_hop_adj_i),
    .q_full_i             (q_full),
    .q_push_o             (q_push),
    .q_item_o             (q_in_item)
  );

  // The queue lets the front keep taking words while the back is busy walking
  // the table or waiting on a stalled output.
  pfsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  // The back owns the flow table and the output register. It finishes one word
  // completely, table update included, before it pops the next.
  pfsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .forward_o      (forward_o),
    .drop_reason_o  (drop_reason_o),
    .strip_bytes_o  (strip_bytes_o),
    .next_hop_out_o (next_hop_out_o)
  );

endmodule

### src/pfsd_checker.sv
// Port-level checker for the per-flow sequence dedup block, bound to the top level.
module pfsd_checker import pfsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              forward_o,
  input  logic [2:0]        drop_reason_o,
  input  logic [HdrW-1:0]   strip_bytes_o,
  input  logic [AdjW-1:0]   next_hop_out_o
);

  // A stalled result word stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(forward_o) &&
      $stable(drop_reason_o) && $stable(strip_bytes_o) && $stable(next_hop_out_o))
    else $error("stalled result word changed");

  // Forwarding and the drop reason agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (forward_o == (drop_reason_o == DrNone)))
    else $error("forward flag disagrees with drop reason");

  // A dropped word carries no strip length and no next hop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !forward_o |-> (strip_bytes_o == '0) && (next_hop_out_o == '0))
    else $error("dropped word carries forwarding data");

  // Only defined drop reasons appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drop_reason_o == DrNone) || (drop_reason_o == DrNoRh) ||
      (drop_reason_o == DrNotLast) || (drop_reason_o == DrDup) ||
      (drop_reason_o == DrNoInner) || (drop_reason_o == DrFull))
    else $error("undefined drop reason");

endmodule

bind per_flow_sequence_dedup pfsd_checker u_pfsd_checker (.*);

### sim/pfsd_dedup_checker.sv
// Checker that predicts and compares every result word of the per-flow dedup block.
`timescale 1ns / 1ps

module pfsd_dedup_checker import pfsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             has_routing_header_i,
  input  logic [SegW-1:0]  segments_left_i,
  input  logic             inner_is_ipv6_i,
  input  logic [FlowW-1:0] flow_id_i,
  input  logic [SeqW-1:0]  seq_num_i,
  input  logic [HdrW-1:0]  header_bytes_i,
  input  logic [AdjW-1:0]  next_hop_adj_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             forward_i,
  input  logic [2:0]       drop_reason_i,
  input  logic [HdrW-1:0]  strip_bytes_i,
  input  logic [AdjW-1:0]  next_hop_out_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic             forward;
    drop_reason_e     reason;
    logic [HdrW-1:0]  strip;
    logic [AdjW-1:0]  hop;
  } verdict_t;

  // Shadow copy of the flow table.
  logic             flow_known [FLOW_ENTRIES];
  logic [FlowW-1:0] flow_tag   [FLOW_ENTRIES];
  logic [SeqW-1:0]  flow_seq   [FLOW_ENTRIES];

  verdict_t expected_verdicts [$];

  // Decides the fate of one descriptor and updates the shadow table.
  function automatic verdict_t classify_descriptor(
    input logic has_rh, input logic [SegW-1:0] seg, input logic inner,
    input logic [FlowW-1:0] flow, input logic [SeqW-1:0] seq,
    input logic [HdrW-1:0] hdr, input logic [AdjW-1:0] adj);
    verdict_t v;
    int hit;
    int spare;
    int i;
    v.forward = 1'b0;
    v.reason  = DrNone;
    v.strip   = '0;
    v.hop     = '0;
    hit   = -1;
    spare = -1;
    if (has_rh && seg != '0) begin
      v.reason = DrNotLast;
    end else if (!inner) begin
      v.reason = DrNoInner;
    end else if (!has_rh) begin
      v.reason = DrNoRh;
    end else begin
      for (i = 0; i < FLOW_ENTRIES; i++) begin
        if (flow_known[i]) begin
          if (hit < 0 && flow_tag[i] == flow) hit = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (hit >= 0 && seq <= flow_seq[hit]) begin
        v.reason = DrDup;
      end else if (hit < 0 && spare < 0) begin
        v.reason = DrFull;
      end else begin
        if (hit >= 0) begin
          flow_seq[hit] = seq;
        end else begin
          flow_known[spare] = 1'b1;
          flow_tag[spare]   = flow;
          flow_seq[spare]   = seq;
        end
        v.forward = 1'b1;
        v.strip   = hdr;
        v.hop     = adj;
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    logic bad;
    if (!rst_ni) begin
      expected_verdicts.delete();
      for (int k = 0; k < FLOW_ENTRIES; k++) flow_known[k] = 1'b0;
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result word with nothing expected (forward %0b reason %0d)",
                   $time, forward_i, drop_reason_i);
          mismatch_count_o++;
        end else begin
          want = expected_verdicts.pop_front();
          bad = 1'b0;
          if (forward_i !== want.forward) begin
            $display("%0t: forward expected %0b got %0b", $time, want.forward, forward_i);
            bad = 1'b1;
          end
          if (drop_reason_i !== want.reason) begin
            $display("%0t: drop_reason expected %0d got %0d", $time, want.reason,
                     drop_reason_i);
            bad = 1'b1;
          end
          if (strip_bytes_i !== want.strip) begin
            $display("%0t: strip_bytes expected %0d got %0d", $time, want.strip,
                     strip_bytes_i);
            bad = 1'b1;
          end
          if (next_hop_out_i !== want.hop) begin
            $display("%0t: next_hop_out expected %0d got %0d", $time, want.hop,
                     next_hop_out_i);
            bad = 1'b1;
          end
          if (bad) mismatch_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_verdicts.push_back(classify_descriptor(has_routing_header_i,
          segments_left_i, inner_is_ipv6_i, flow_id_i, seq_num_i, header_bytes_i,
          next_hop_adj_i));
      end
      pending_o = expected_verdicts.size();
    end
  end

endmodule

### sim/per_flow_sequence_dedup_tb.sv
// Testbench top: drives descriptors and output stalls into the dedup block and gives the verdict.
`timescale 1ns / 1ps

module per_flow_sequence_dedup_tb;
  import pfsd_pkg::*;

  // A miss walks every stored flow through the read and compare states, so the drain
  // after the last word allows a full table walk with room to spare.
  localparam int unsigned DrainCycles   = 4 * FLOW_ENTRIES + 16;
  // Longest legal stretch without a word moving is the long receiver hold-off
  // plus one table walk; the watchdog limit sits well above that.
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned PoolSize      = 80;
  localparam int unsigned RandomWords   = 930;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             has_routing_header_i;
  logic [SegW-1:0]  segments_left_i;
  logic             inner_is_ipv6_i;
  logic [FlowW-1:0] flow_id_i;
  logic [SeqW-1:0]  seq_num_i;
  logic [HdrW-1:0]  header_bytes_i;
  logic [AdjW-1:0]  next_hop_adj_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             forward_o;
  logic [2:0]       drop_reason_o;
  logic [HdrW-1:0]  strip_bytes_o;
  logic [AdjW-1:0]  next_hop_out_o;

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned words_offered;
  int unsigned idle_cycles;
  logic        hold_off_done;

  // Flows that the random traffic draws from. There are more of them than table
  // entries, so the table fills up and later new flows are refused.
  logic [FlowW-1:0] flow_pool [PoolSize];
  logic [SeqW-1:0]  pool_seq  [PoolSize];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  per_flow_sequence_dedup dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .has_routing_header_i (has_routing_header_i),
    .segments_left_i      (segments_left_i),
    .inner_is_ipv6_i      (inner_is_ipv6_i),
    .flow_id_i            (flow_id_i),
    .seq_num_i            (seq_num_i),
    .header_bytes_i       (header_bytes_i),
    .next_hop_adj_i       (next_hop_adj_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .forward_o            (forward_o),
    .drop_reason_o        (drop_reason_o),
    .strip_bytes_o        (strip_bytes_o),
    .next_hop_out_o       (next_hop_out_o)
  );

  pfsd_dedup_checker dedup_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .has_routing_header_i (has_routing_header_i),
    .segments_left_i      (segments_left_i),
    .inner_is_ipv6_i      (inner_is_ipv6_i),
    .flow_id_i            (flow_id_i),
    .seq_num_i            (seq_num_i),
    .header_bytes_i       (header_bytes_i),
    .next_hop_adj_i       (next_hop_adj_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .forward_i            (forward_o),
    .drop_reason_i        (drop_reason_o),
    .strip_bytes_i        (strip_bytes_o),
    .next_hop_out_i       (next_hop_out_o),
    .mismatch_count_o     (mismatch_count),
    .pending_o            (pending_words)
  );

  // Idle cycles before a word. Every third block of 64 words runs back to back;
  // elsewhere most gaps are short and a few are long.
  function automatic int unsigned pick_gap(input int unsigned idx);
    int unsigned roll;
    roll = $urandom_range(99);
    if ((idx / 64) % 3 == 0) return 0;
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one descriptor after an optional gap and returns at the clock edge
  // where the block takes it. Valid stays high when the next word follows with
  // no gap, so it is never lowered and raised in the same time step.
  task automatic offer_word(input logic has_rh, input logic [SegW-1:0] seg,
                            input logic inner, input logic [FlowW-1:0] flow,
                            input logic [SeqW-1:0] seq, input logic [HdrW-1:0] hdr,
                            input logic [AdjW-1:0] adj, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    has_routing_header_i <= has_rh;
    segments_left_i      <= seg;
    inner_is_ipv6_i      <= inner;
    flow_id_i            <= flow;
    seq_num_i            <= seq;
    header_bytes_i       <= hdr;
    next_hop_adj_i       <= adj;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_offered++;
  endtask

  // Receiver side. Stalls come in random runs, mostly short, a few long, with
  // occasional long stretches of no stall at all. Once, after a couple hundred
  // words, the receiver holds off long enough that the internal queue and the
  // output register fill and the block has to stall its input.
  initial begin : receiver
    int unsigned roll;
    out_stall_i   <= 1'b0;
    hold_off_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      roll = $urandom_range(99);
      if (!hold_off_done && words_offered >= 250) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (roll < 50) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (roll < 85) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (roll < 95) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(8, 40)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 150)) @(posedge clk_i);
      end
    end
  end

  // The watchdog only counts cycles in which no word moves on either side, so a
  // hung handshake ends the run however far along it is.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("** per_flow_sequence_dedup: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sender
    int unsigned      n;
    int unsigned      p;
    int unsigned      sel;
    logic [SeqW-1:0]  seq;
    logic [HdrW-1:0]  hdr;
    rst_ni               <= 1'b0;
    in_valid_i           <= 1'b0;
    has_routing_header_i <= 1'b0;
    segments_left_i      <= '0;
    inner_is_ipv6_i      <= 1'b0;
    flow_id_i            <= '0;
    seq_num_i            <= '0;
    header_bytes_i       <= '0;
    next_hop_adj_i       <= '0;
    words_offered        = 0;

    // The first three pool flows are the ones the directed words insert. Every
    // fourth random flow differs from its neighbor in a single bit, so the tag
    // compare has to look at all 32 bits.
    flow_pool[0] = 32'h0000_0000;
    flow_pool[1] = 32'hFFFF_FFFF;
    flow_pool[2] = 32'h1234_5678;
    pool_seq[0]  = 16'hFFFF;
    pool_seq[1]  = 16'hFFFF;
    pool_seq[2]  = 16'd102;
    for (int i = 3; i < PoolSize; i++) begin
      if (i % 4 == 0) flow_pool[i] = flow_pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
      else flow_pool[i] = $urandom;
      pool_seq[i] = 16'($urandom_range(0, 50000));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words. Check order first: the not-last-segment test beats the
    // inner IPv6 test, which beats the missing routing header test, and
    // segments left means nothing without a routing header.
    offer_word(1'b0, 8'd0,   1'b1, 32'hA5A5_0001, 16'd5, 16'd60, 20'd7, 0);
    offer_word(1'b0, 8'd255, 1'b1, 32'hA5A5_0001, 16'd5, 16'd60, 20'd7, 0);
    offer_word(1'b1, 8'd255, 1'b1, 32'hA5A5_0002, 16'd5, 16'd60, 20'd7, 1);
    offer_word(1'b1, 8'd1,   1'b0, 32'hA5A5_0002, 16'd5, 16'd60, 20'd7, 0);
    offer_word(1'b1, 8'd0,   1'b0, 32'hA5A5_0003, 16'd5, 16'd60, 20'd7, 0);
    offer_word(1'b0, 8'd128, 1'b0, 32'hA5A5_0003, 16'd5, 16'd60, 20'd7, 2);
    // Insertion at the field extremes, then equal and lower sequence numbers,
    // which must both be dropped as duplicates.
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'd0,      16'd0,      20'd0,       0);
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'd0,      16'd100,    20'd1,       0);
    offer_word(1'b1, 8'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,   16'hFFFF,   20'hFFFFF,   0);
    offer_word(1'b1, 8'd0, 1'b1, 32'hFFFF_FFFF, 16'd0,      16'd80,     20'd3,       0);
    offer_word(1'b1, 8'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,   16'd80,     20'd3,       3);
    // A higher sequence number updates the stored value; the compare is plain
    // unsigned, so the jump to the top value is not seen as a wrap.
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'd1,      16'd40,     20'h55555,   0);
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'd1,      16'd40,     20'h55555,   0);
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'hFFFF,   16'd48,     20'hAAAAA,   0);
    offer_word(1'b1, 8'd0, 1'b1, 32'h0000_0000, 16'h8000,   16'd48,     20'hAAAAA,   0);
    // Header length below the legal minimum is passed through untouched.
    offer_word(1'b1, 8'd0, 1'b1, 32'h1234_5678, 16'd100,    16'd39,     20'd12345,   1);
    offer_word(1'b1, 8'd0, 1'b1, 32'h1234_5678, 16'd101,    16'd1,      20'd54321,   0);
    // A dropped word for a known flow must leave its entry alone.
    offer_word(1'b1, 8'd0, 1'b0, 32'h1234_5678, 16'd900,    16'd64,     20'd9,       0);
    offer_word(1'b1, 8'd0, 1'b1, 32'h1234_5678, 16'd102,    16'd72,     20'd10,      0);

    // Random part: mostly well-formed descriptors on pool flows with sequence
    // numbers near the last one sent, so forwards, duplicates and reordering
    // all occur. The rest is noise on every field. The pool outgrows the table,
    // so the table-full case shows up and is then exercised on every miss.
    for (n = 0; n < RandomWords; n++) begin
      p   = $urandom_range(0, PoolSize - 1);
      hdr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40, 400));
      if ($urandom_range(99) < 80) begin
        sel = $urandom_range(99);
        if (sel < 55) begin
          seq = (pool_seq[p] > 16'hFFF0) ? 16'hFFFF : pool_seq[p] + 16'($urandom_range(1, 8));
        end else if (sel < 75) begin
          seq = pool_seq[p];
        end else if (sel < 90) begin
          seq = (pool_seq[p] < 16'd8) ? 16'd0 : pool_seq[p] - 16'($urandom_range(0, 8));
        end else begin
          seq = 16'($urandom);
        end
        offer_word(1'b1, 8'd0, 1'b1, flow_pool[p], seq, hdr, 20'($urandom), pick_gap(n));
        if (seq > pool_seq[p]) pool_seq[p] = seq;
      end else begin
        offer_word(1'($urandom), ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom),
                   1'($urandom), ($urandom_range(1) == 0) ? flow_pool[p] : 32'($urandom),
                   16'($urandom), hdr, 20'($urandom), pick_gap(n));
      end
    end
    in_valid_i <= 1'b0;

    // The checker updates its counts at the rising edge, so they are read at
    // the falling edge, where they are settled.
    @(negedge clk_i);
    while (pending_words != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("** per_flow_sequence_dedup: PASSED **");
    end else begin
      $display("** per_flow_sequence_dedup: FAILED **");
    end
    $finish;
  end

endmodule
